// ===== sv/u8cyr_pkg.sv =====
package u8cyr_pkg;

  // Lead-byte holding codes.
  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_D0   = 2'd1;
  localparam logic [1:0] PEND_D1   = 2'd2;

  // Two of the UTF-8 lead bytes of the Cyrillic block, and the continuation-byte tag.
  localparam logic [7:0] LEAD_LO    = 8'hD0;
  localparam logic [7:0] LEAD_HI    = 8'hD1;
  localparam logic [1:0] FOLLOW_TAG = 2'b10;

  localparam int unsigned MaxChars = 3;

  // A run of one to three output characters; chr[0] goes out first.
  typedef struct packed {
    logic [1:0]                 len;
    logic [MaxChars-1:0][7:0]   chr;
  } seq_t;

  function automatic seq_t mk_seq(input logic [1:0] n, input logic [7:0] a,
                                  input logic [7:0] b, input logic [7:0] c);
    seq_t s;
    s.len    = n;
    s.chr[0] = a;
    s.chr[1] = b;
    s.chr[2] = c;
    return s;
  endfunction

  // Latin spelling of one lead/follow pair. The row bit selects lead 0xD1,
  // the low six bits are the follow byte minus 0x80. Pairs not in the
  // table come back with zero length.
  function automatic seq_t map_pair(input logic row, input logic [5:0] idx);
    seq_t s;
    s = mk_seq(2'd0, 8'h00, 8'h00, 8'h00);
    case ({row, idx})
      7'h01: s = mk_seq(2'd2, "Y", "O", 8'h00);
      7'h10: s = mk_seq(2'd1, "A", 8'h00, 8'h00);
      7'h11: s = mk_seq(2'd1, "B", 8'h00, 8'h00);
      7'h12: s = mk_seq(2'd1, "V", 8'h00, 8'h00);
      7'h13: s = mk_seq(2'd1, "G", 8'h00, 8'h00);
      7'h14: s = mk_seq(2'd1, "D", 8'h00, 8'h00);
      7'h15: s = mk_seq(2'd1, "E", 8'h00, 8'h00);
      7'h16: s = mk_seq(2'd2, "Z", "H", 8'h00);
      7'h17: s = mk_seq(2'd1, "Z", 8'h00, 8'h00);
      7'h18: s = mk_seq(2'd1, "I", 8'h00, 8'h00);
      7'h19: s = mk_seq(2'd1, "Y", 8'h00, 8'h00);
      7'h1A: s = mk_seq(2'd1, "K", 8'h00, 8'h00);
      7'h1B: s = mk_seq(2'd1, "L", 8'h00, 8'h00);
      7'h1C: s = mk_seq(2'd1, "M", 8'h00, 8'h00);
      7'h1D: s = mk_seq(2'd1, "N", 8'h00, 8'h00);
      7'h1E: s = mk_seq(2'd1, "O", 8'h00, 8'h00);
      7'h1F: s = mk_seq(2'd1, "P", 8'h00, 8'h00);
      7'h20: s = mk_seq(2'd1, "R", 8'h00, 8'h00);
      7'h21: s = mk_seq(2'd1, "S", 8'h00, 8'h00);
      7'h22: s = mk_seq(2'd1, "T", 8'h00, 8'h00);
      7'h23: s = mk_seq(2'd1, "U", 8'h00, 8'h00);
      7'h24: s = mk_seq(2'd1, "F", 8'h00, 8'h00);
      7'h25: s = mk_seq(2'd1, "H", 8'h00, 8'h00);
      7'h26: s = mk_seq(2'd1, "C", 8'h00, 8'h00);
      7'h27: s = mk_seq(2'd2, "C", "H", 8'h00);
      7'h28: s = mk_seq(2'd2, "S", "H", 8'h00);
      7'h29: s = mk_seq(2'd3, "S", "C", "H");
      7'h2A: s = mk_seq(2'd1, "|", 8'h00, 8'h00);
      7'h2B: s = mk_seq(2'd1, "Y", 8'h00, 8'h00);
      7'h2C: s = mk_seq(2'd1, "/", 8'h00, 8'h00);
      7'h2D: s = mk_seq(2'd2, "E", "H", 8'h00);
      7'h2E: s = mk_seq(2'd2, "Y", "U", 8'h00);
      7'h2F: s = mk_seq(2'd2, "Y", "A", 8'h00);
      7'h30: s = mk_seq(2'd1, "a", 8'h00, 8'h00);
      7'h31: s = mk_seq(2'd1, "b", 8'h00, 8'h00);
      7'h32: s = mk_seq(2'd1, "v", 8'h00, 8'h00);
      7'h33: s = mk_seq(2'd1, "g", 8'h00, 8'h00);
      7'h34: s = mk_seq(2'd1, "d", 8'h00, 8'h00);
      7'h35: s = mk_seq(2'd1, "e", 8'h00, 8'h00);
      7'h36: s = mk_seq(2'd2, "z", "h", 8'h00);
      7'h37: s = mk_seq(2'd1, "z", 8'h00, 8'h00);
      7'h38: s = mk_seq(2'd1, "i", 8'h00, 8'h00);
      7'h39: s = mk_seq(2'd1, "y", 8'h00, 8'h00);
      7'h3A: s = mk_seq(2'd1, "k", 8'h00, 8'h00);
      7'h3B: s = mk_seq(2'd1, "l", 8'h00, 8'h00);
      7'h3C: s = mk_seq(2'd1, "m", 8'h00, 8'h00);
      7'h3D: s = mk_seq(2'd1, "n", 8'h00, 8'h00);
      7'h3E: s = mk_seq(2'd1, "o", 8'h00, 8'h00);
      7'h3F: s = mk_seq(2'd1, "p", 8'h00, 8'h00);
      7'h40: s = mk_seq(2'd1, "r", 8'h00, 8'h00);
      7'h41: s = mk_seq(2'd1, "s", 8'h00, 8'h00);
      7'h42: s = mk_seq(2'd1, "t", 8'h00, 8'h00);
      7'h43: s = mk_seq(2'd1, "u", 8'h00, 8'h00);
      7'h44: s = mk_seq(2'd1, "f", 8'h00, 8'h00);
      7'h45: s = mk_seq(2'd1, "h", 8'h00, 8'h00);
      7'h46: s = mk_seq(2'd1, "c", 8'h00, 8'h00);
      7'h47: s = mk_seq(2'd2, "c", "h", 8'h00);
      7'h48: s = mk_seq(2'd2, "s", "h", 8'h00);
      7'h49: s = mk_seq(2'd3, "s", "c", "h");
      7'h4A: s = mk_seq(2'd1, "|", 8'h00, 8'h00);
      7'h4B: s = mk_seq(2'd1, "y", 8'h00, 8'h00);
      7'h4C: s = mk_seq(2'd1, "/", 8'h00, 8'h00);
      7'h4D: s = mk_seq(2'd2, "e", "h", 8'h00);
      7'h4E: s = mk_seq(2'd2, "y", "u", 8'h00);
      7'h4F: s = mk_seq(2'd2, "y", "a", 8'h00);
      7'h51: s = mk_seq(2'd2, "y", "o", 8'h00);
      default: s = mk_seq(2'd0, 8'h00, 8'h00, 8'h00);
    endcase
    return s;
  endfunction

endpackage

// ===== sv/utf8_cyrillic_transliterator.sv =====
// UTF-8 Cyrillic to Latin transliterator.
// Input channel (in_valid_i/in_ready_o/in_byte_i) takes one byte of a UTF-8
// stream per transfer. Output channel (out_valid_o/out_ready_i) delivers one
// character per transfer; out_last_o marks the final character of the run
// that one input byte causes.
// A lead byte 0xD0 or 0xD1 is held and produces nothing; the next byte is
// its follow byte, and the pair yields one to three Latin characters, or
// nothing for a byte without the follow tag or a pair not in the table.
// Any other byte passes through. An accepted byte goes through the input
// register and then the result register before its first character shows.
// Pass-through bytes move at one per cycle while the receiver takes every
// character; a pair spelling n characters holds the result register until
// all n are taken; the output port (one character per cycle) sets the rate.
// The input register keeps taking a byte while the result register still
// waits, and a byte held there moves on in the same cycle that the last
// character of the previous run is taken. When the receiver stalls, both
// registers fill and in_ready_o drops. Reset empties both registers and
// forgets any pending lead byte.
module utf8_cyrillic_transliterator (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       out_last_o
);
  import u8cyr_pkg::*;

  logic       in_vld_q, in_vld_d;
  logic [7:0] in_byte_q;
  logic [1:0] pend_q, pend_d;
  logic       seq_vld_q, seq_vld_d;
  seq_t       seq_q, seq_d, seq_new;
  logic [1:0] seq_idx_q, seq_idx_d;
  logic       out_fire, out_done, advance;

  // Output handshake and the point where the result register frees up.
  assign out_fire = seq_vld_q && out_ready_i;
  assign out_done = out_fire && out_last_o;
  assign advance  = in_vld_q && (!seq_vld_q || out_done);
  assign in_ready_o = !in_vld_q || advance;

  // Decode the held byte against the pending lead.
  always_comb begin
    pend_d  = pend_q;
    seq_new = mk_seq(2'd0, 8'h00, 8'h00, 8'h00);
    if (pend_q == PEND_D0 || pend_q == PEND_D1) begin
      pend_d = PEND_NONE;
      if (in_byte_q[7:6] == FOLLOW_TAG) begin
        seq_new = map_pair(pend_q == PEND_D1, in_byte_q[5:0]);
      end
    end else if (in_byte_q == LEAD_LO) begin
      pend_d = PEND_D0;
    end else if (in_byte_q == LEAD_HI) begin
      pend_d = PEND_D1;
    end else begin
      pend_d  = PEND_NONE;
      seq_new = mk_seq(2'd1, in_byte_q, 8'h00, 8'h00);
    end
    if (!advance) begin
      pend_d = pend_q;
    end
  end

  // Input register control.
  always_comb begin
    in_vld_d = in_vld_q;
    if (in_valid_i && in_ready_o) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  // Result register: load a new run or step through the current one.
  always_comb begin
    seq_vld_d = seq_vld_q;
    seq_d     = seq_q;
    seq_idx_d = seq_idx_q;
    if (advance) begin
      seq_vld_d = (seq_new.len != 2'd0);
      seq_d     = seq_new;
      seq_idx_d = 2'd0;
    end else if (out_done) begin
      seq_vld_d = 1'b0;
    end else if (out_fire) begin
      seq_idx_d = seq_idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      pend_q    <= PEND_NONE;
      seq_vld_q <= 1'b0;
      seq_idx_q <= 2'd0;
    end else begin
      in_vld_q  <= in_vld_d;
      pend_q    <= pend_d;
      seq_vld_q <= seq_vld_d;
      seq_idx_q <= seq_idx_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= in_byte_i;
    end
    seq_q <= seq_d;
  end

  assign out_valid_o = seq_vld_q;
  assign out_char_o  = seq_q.chr[seq_idx_q];
  assign out_last_o  = (seq_idx_q == seq_q.len - 2'd1);

  // The character index never runs past the end of the run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    seq_vld_q |-> (seq_q.len != 2'd0 && seq_idx_q < seq_q.len))
    else $error("character index outside the loaded run");

  // The unused lead code never appears.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("invalid pending lead code");

  // A taken character that is not the last leaves the run in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !out_last_o) |=> (seq_vld_q && seq_idx_q == $past(seq_idx_q) + 2'd1))
    else $error("run lost before its last character");

  // A held byte is never dropped while the result register is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && seq_vld_q && !out_done) |=> in_vld_q)
    else $error("held byte dropped during a stall");

endmodule
